// ----- rtl/core/modexp_pkg.sv -----
package modexp_pkg;

   localparam int BASE_BITS = 16;

   typedef struct packed {
      logic load;
      logic mul_acc;
      logic mul_sq;
      logic red_step;
      logic wr_acc;
      logic wr_sq;
      logic next_bit;
      logic emit;
   } modexp_cmd_type;

   typedef struct packed {
      logic red_done;
      logic exp_lsb;
      logic last_bit;
      logic mod_zero;
   } modexp_status_type;

endpackage

// ----- rtl/core/modexp_if.sv -----
interface modexp_req_if #(
   parameter int EXP_BITS = 8,
   parameter int MOD_BITS = 16
);
   import modexp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BASE_BITS-1:0] base;
   logic [EXP_BITS-1:0]  exponent;
   logic [MOD_BITS-1:0]  modulus;

   modport source (output valid, base, exponent, modulus, input ready);
   modport sink (input valid, base, exponent, modulus, output ready);
endinterface

interface modexp_rsp_if #(
   parameter int MOD_BITS = 16
);
   logic                valid;
   logic                ready;
   logic [MOD_BITS-1:0] residue_out;
   logic                bad_modulus;

   modport source (output valid, residue_out, bad_modulus, input ready);
   modport sink (input valid, residue_out, bad_modulus, output ready);
endinterface

// ----- rtl/core/modexp_datapath.sv -----
module modexp_datapath
   import modexp_pkg::*;
#(
   parameter int EXP_BITS = 8,
   parameter int MOD_BITS = 16
) (
   input  logic                 clock,
   input  modexp_cmd_type       cmd,
   output modexp_status_type    status,
   input  logic [BASE_BITS-1:0] base,
   input  logic [EXP_BITS-1:0]  exponent,
   input  logic [MOD_BITS-1:0]  modulus,
   output logic [MOD_BITS-1:0]  residue_out,
   output logic                 bad_modulus
);

   localparam int PW = 2 * MOD_BITS;
   localparam int DW = (PW > BASE_BITS) ? PW : BASE_BITS;
   localparam int CW = $clog2(DW + 1);
   localparam int BW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

   logic [MOD_BITS-1:0] mod_ff, mod_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] sq_ff, sq_in;
   logic [DW-1:0]       div_ff, div_in;
   logic [MOD_BITS-1:0] rem_ff, rem_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [BW-1:0]       bit_ff, bit_in;
   logic [MOD_BITS-1:0] res_ff, res_in;
   logic                bad_ff, bad_in;

   logic [MOD_BITS-1:0] op_a;
   logic [PW-1:0]       prod;
   logic [MOD_BITS:0]   trial;
   logic [MOD_BITS:0]   diff;
   logic [MOD_BITS-1:0] step_rem;

   assign op_a = cmd.mul_acc ? acc_ff : sq_ff;
   assign prod = {{MOD_BITS{1'b0}}, op_a} * {{MOD_BITS{1'b0}}, sq_ff};

   // restoring remainder, one dividend bit per cycle
   assign trial    = {rem_ff, div_ff[DW-1]};
   assign diff     = trial - {1'b0, mod_ff};
   assign step_rem = (trial >= {1'b0, mod_ff}) ? diff[MOD_BITS-1:0] : trial[MOD_BITS-1:0];

   always_comb begin
      mod_in = mod_ff;
      exp_in = exp_ff;
      acc_in = acc_ff;
      sq_in  = sq_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      bit_in = bit_ff;
      res_in = res_ff;
      bad_in = bad_ff;
      if (cmd.load) begin
         mod_in = modulus;
         exp_in = exponent;
         acc_in = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
         div_in = DW'(base);
         rem_in = '0;
         cnt_in = '0;
         bit_in = '0;
      end
      if (cmd.wr_acc) begin
         acc_in = rem_ff;
      end
      if (cmd.wr_sq) begin
         sq_in = rem_ff;
      end
      if (cmd.mul_acc || cmd.mul_sq) begin
         div_in = DW'(prod);
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.red_step) begin
         div_in = {div_ff[DW-2:0], 1'b0};
         rem_in = step_rem;
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.next_bit) begin
         exp_in = exp_ff >> 1;
         bit_in = bit_ff + BW'(1);
      end
      if (cmd.emit) begin
         bad_in = (mod_ff == '0);
         res_in = (mod_ff == '0) ? '0 : acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      mod_ff <= mod_in;
      exp_ff <= exp_in;
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      bit_ff <= bit_in;
      res_ff <= res_in;
      bad_ff <= bad_in;
   end

   assign status.red_done = (cnt_ff == CW'(DW));
   assign status.exp_lsb  = exp_ff[0];
   assign status.last_bit = (bit_ff == BW'(EXP_BITS - 1));
   assign status.mod_zero = (mod_ff == '0);

   assign residue_out = res_ff;
   assign bad_modulus = bad_ff;

endmodule

// ----- rtl/core/modexp_ctrl.sv -----
module modexp_ctrl
   import modexp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  modexp_status_type status,
   output modexp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RBASE = 3'd1;
   localparam logic [2:0] S_BIT   = 3'd2;
   localparam logic [2:0] S_RACC  = 3'd3;
   localparam logic [2:0] S_RSQ   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RBASE;
            end
         end
         S_RBASE: begin
            if (status.mod_zero) begin
               state_in = S_DONE;
            end else if (status.red_done) begin
               cmd.wr_sq = 1'b1;
               state_in  = S_BIT;
            end else begin
               cmd.red_step = 1'b1;
            end
         end
         S_BIT: begin
            if (status.exp_lsb) begin
               cmd.mul_acc = 1'b1;
               state_in    = S_RACC;
            end else begin
               cmd.mul_sq = 1'b1;
               state_in   = S_RSQ;
            end
         end
         S_RACC: begin
            if (status.red_done) begin
               cmd.wr_acc = 1'b1;
               cmd.mul_sq = 1'b1;
               state_in   = S_RSQ;
            end else begin
               cmd.red_step = 1'b1;
            end
         end
         S_RSQ: begin
            if (status.red_done) begin
               cmd.wr_sq = 1'b1;
               if (status.last_bit) begin
                  state_in = S_DONE;
               end else begin
                  cmd.next_bit = 1'b1;
                  state_in     = S_BIT;
               end
            end else begin
               cmd.red_step = 1'b1;
            end
         end
         S_DONE: begin
            if (!valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ----- rtl/core/modular_exponentiation.sv -----
// Modular exponentiation, square and multiply.
// req_port takes one word: base, exponent and modulus; rsp_port returns one
// word per request: residue_out = base^exponent mod modulus, bad_modulus.
// Both channels move a word when valid and ready are high at a clock edge.
// One request at a time: req_port.ready is high only while the core is idle.
// The base is first reduced modulo the modulus by the restoring remainder
// over DW = max(2*MOD_BITS, 16) dividend bits. Then each exponent bit, LSB
// first, issues a multiply into the accumulator when it is set, and a square;
// each product is reduced the same way, and the square after a multiply
// issues in the same cycle that the multiply's result is written back.
// An output step ends it; the next request is taken only after that step.
// A zero modulus skips the arithmetic and answers with bad_modulus set and
// residue 0.
// The result sits in an output register, so the core may finish the next
// computation while the receiver stalls; it then holds until the slot frees.
// Synchronous active-high reset returns the controller to idle and drops
// rsp_port.valid; the datapath registers are not reset.
module modular_exponentiation
   import modexp_pkg::*;
#(
   parameter int EXP_BITS = 8,
   parameter int MOD_BITS = 16
) (
   input logic          clock,
   input logic          reset,
   modexp_req_if.sink   req_port,
   modexp_rsp_if.source rsp_port
);

   modexp_cmd_type    cmd;
   modexp_status_type status;

   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   modexp_datapath #(
      .EXP_BITS (EXP_BITS),
      .MOD_BITS (MOD_BITS)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .status      (status),
      .base        (req_port.base),
      .exponent    (req_port.exponent),
      .modulus     (req_port.modulus),
      .residue_out (rsp_port.residue_out),
      .bad_modulus (rsp_port.bad_modulus)
   );

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.bad_modulus) |-> (rsp_port.residue_out == '0))
      else $error("bad modulus with nonzero residue");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("request taken while busy");

   a_load_while_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_port.ready && !cmd.emit))
      else $error("load outside idle");

endmodule
